FILE: hdl/mahalanobis_color_mask_centroid_unit_macros.svh
// Assertion macros for the color mask centroid unit checker
`ifndef MAHALANOBIS_COLOR_MASK_CENTROID_UNIT_MACROS_SVH
`define MAHALANOBIS_COLOR_MASK_CENTROID_UNIT_MACROS_SVH

// same-cycle implication
`define MCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mcm_pkg.sv
// Shared types and constants of the color mask centroid unit
`timescale 1ns / 1ps
package mcm_pkg;

  localparam int HIT_W = 23;
  localparam logic [HIT_W-1:0] HIT_MAX = '1;
  localparam int SUM_W = 36;
  localparam int OUT_W = 12;

  localparam logic [2:0] REG_MEAN_BGR   = 3'd0;
  localparam logic [2:0] REG_INV_COV_BB = 3'd1;
  localparam logic [2:0] REG_INV_COV_GG = 3'd2;
  localparam logic [2:0] REG_INV_COV_RR = 3'd3;
  localparam logic [2:0] REG_INV_COV_BG = 3'd4;
  localparam logic [2:0] REG_INV_COV_BR = 3'd5;
  localparam logic [2:0] REG_INV_COV_GR = 3'd6;
  localparam logic [2:0] REG_THRESHOLD  = 3'd7;

  typedef struct packed {
    logic             in_mask;
    logic             frame_end;
    logic [HIT_W-1:0] hits;
    logic [SUM_W-1:0] sum_col;
    logic [SUM_W-1:0] sum_row;
  } front_word_t;

endpackage

FILE: hdl/mahalanobis_color_mask_centroid_unit.sv
// Top level of the Mahalanobis color mask centroid unit
// Pixel flow: accept, product, seven multiply-accumulate steps on the front's
// shared 20x32 multiplier, compare and push; the front takes a new pixel
// only after the push, which waits while the queue is full. Frame-end words
// with hits then pass through the bit-serial centroid divider.
// Reset: synchronous, clears state, sums and counters; threshold resets to 30.
`timescale 1ns / 1ps
module mahalanobis_color_mask_centroid_unit #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 2048,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // blue, green, red
  input  logic        s_tuser,   // line_end
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // inside_res, centroid_x, centroid_y, zero fill
  output logic        m_tlast    // centroid_valid
);
  import mcm_pkg::*;

  front_word_t fw, qw;
  logic push, full, pop, empty;

  mcm_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .blue(s_tdata[7:0]), .green(s_tdata[15:8]), .red(s_tdata[23:16]),
    .line_end(s_tuser), .frame_end(s_tlast),
    .word(fw), .push(push), .full(full)
  );

  mcm_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .wdata(fw), .full(full),
    .pop(pop), .rdata(qw), .empty(empty)
  );

  mcm_back u_back (
    .clk(clk), .rst(rst),
    .word(qw), .empty(empty), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

endmodule

FILE: hdl/mcm_front.sv
// Front end: config registers, distance classification, position and sum tracking
`timescale 1ns / 1ps
module mcm_front #(
  parameter int MAX_WIDTH      = 2048,
  parameter int MAX_HEIGHT     = 2048,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          blue,
  input  logic [7:0]          green,
  input  logic [7:0]          red,
  input  logic                line_end,
  input  logic                frame_end,
  output mcm_pkg::front_word_t word,
  output logic                push,
  input  logic                full
);
  import mcm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_HEIGHT - 1);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_PROD = 5'b00010,
    F_MAC  = 5'b00100,
    F_CMP  = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state;
  logic [23:0] mean_bgr;
  logic signed [31:0] coef [6];
  logic [15:0] threshold;

  logic signed [8:0] db, dg, dr;
  logic signed [19:0] prod_q [6];
  logic signed [51:0] prod_r;
  logic pv;
  logic [2:0] idx;
  logic signed [55:0] acc;
  logic inside_r, le_r, fe_r;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [SUM_W-1:0] sum_columns, sum_rows, sum_columns_next, sum_rows_next;
  logic [HIT_W-1:0] hit_count, hit_count_next;

  logic signed [63:0] lhs;
  logic [31:0] tt;
  logic [63:0] rhs;
  logic inside_cmp, hit;

  assign in_ready = (state == F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_bgr <= '0;
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      threshold <= 16'd30;
    end else if (cfg_we) begin
      if (cfg_index == REG_MEAN_BGR) begin
        mean_bgr <= cfg_data[23:0];
      end else if (cfg_index == REG_THRESHOLD) begin
        threshold <= cfg_data[15:0];
      end else if (cfg_index >= REG_INV_COV_BB && cfg_index <= REG_INV_COV_GR) begin
        coef[3'(cfg_index - REG_INV_COV_BB)] <= cfg_data;
      end
    end
  end

  assign lhs = (64'(acc) <<< 6) + (64'(acc) <<< 5) + (64'(acc) <<< 2);
  assign tt = 32'(threshold) * 32'(threshold);
  assign rhs = {32'b0, tt} << COEF_FRAC_BITS;
  assign inside_cmp = lhs[63] || ($unsigned(lhs) <= rhs);

  assign hit = inside_r && (hit_count != HIT_MAX);
  assign hit_count_next = hit ? hit_count + 1'b1 : hit_count;
  assign sum_columns_next = hit ? sum_columns + SUM_W'(column_count) : sum_columns;
  assign sum_rows_next = hit ? sum_rows + SUM_W'(row_count) : sum_rows;

  assign word.in_mask = inside_r;
  assign word.frame_end = fe_r;
  assign word.hits = hit_count_next;
  assign word.sum_col = sum_columns_next;
  assign word.sum_row = sum_rows_next;
  assign push = (state == F_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      column_count <= '0;
      row_count <= '0;
      sum_columns <= '0;
      sum_rows <= '0;
      hit_count <= '0;
      pv <= 1'b0;
      idx <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            db <= $signed({1'b0, blue}) - $signed({1'b0, mean_bgr[7:0]});
            dg <= $signed({1'b0, green}) - $signed({1'b0, mean_bgr[15:8]});
            dr <= $signed({1'b0, red}) - $signed({1'b0, mean_bgr[23:16]});
            le_r <= line_end;
            fe_r <= frame_end;
            state <= F_PROD;
          end
        end
        F_PROD: begin
          prod_q[0] <= db * db;
          prod_q[1] <= dg * dg;
          prod_q[2] <= dr * dr;
          prod_q[3] <= (db * dg) <<< 1;
          prod_q[4] <= (db * dr) <<< 1;
          prod_q[5] <= (dg * dr) <<< 1;
          acc <= '0;
          idx <= '0;
          pv <= 1'b0;
          state <= F_MAC;
        end
        F_MAC: begin
          if (pv) acc <= acc + 56'(prod_r);
          if (idx != 3'd6) begin
            prod_r <= prod_q[idx] * coef[idx];
            pv <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            pv <= 1'b0;
            state <= F_CMP;
          end
        end
        F_CMP: begin
          inside_r <= inside_cmp;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
            if (fe_r) begin
              hit_count <= '0;
              sum_columns <= '0;
              sum_rows <= '0;
              column_count <= '0;
              row_count <= '0;
            end else begin
              hit_count <= hit_count_next;
              sum_columns <= sum_columns_next;
              sum_rows <= sum_rows_next;
              if (le_r) begin
                column_count <= '0;
                if (row_count != ROW_LAST) row_count <= row_count + 1'b1;
              end else if (column_count != COL_LAST) begin
                column_count <= column_count + 1'b1;
              end
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/mcm_queue.sv
// Two-entry queue between front and back
`timescale 1ns / 1ps
module mcm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mcm_pkg::front_word_t wdata,
  output logic                 full,
  input  logic                 pop,
  output mcm_pkg::front_word_t rdata,
  output logic                 empty
);
  import mcm_pkg::*;

  front_word_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hdl/mcm_back.sv
// Back end: centroid division and output register
`timescale 1ns / 1ps
module mcm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mcm_pkg::front_word_t word,
  input  logic                 empty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          m_tdata,
  output logic                 m_tlast
);
  import mcm_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SUM_W - 1);
  localparam logic [OUT_W-1:0] NONE = '1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } bstate_t;

  bstate_t state;
  logic out_free, start_div, direct;
  logic [SUM_W-1:0] qx, qy;
  logic [HIT_W-1:0] rx, ry, dv;
  logic [CNT_W-1:0] cnt;
  logic [HIT_W:0] shx, shy;
  logic gex, gey;
  logic inside_r;

  assign out_free = !m_tvalid || m_tready;
  assign start_div = word.frame_end && (word.hits != '0);
  assign pop = (state == B_IDLE) && !empty && out_free;
  assign direct = pop && !start_div;

  assign shx = {rx, qx[SUM_W-1]};
  assign shy = {ry, qy[SUM_W-1]};
  assign gex = shx >= {1'b0, dv};
  assign gey = shy >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      m_tvalid <= 1'b0;
      cnt <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (pop && start_div) begin
            qx <= word.sum_col;
            qy <= word.sum_row;
            rx <= '0;
            ry <= '0;
            dv <= word.hits;
            inside_r <= word.in_mask;
            cnt <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          qx <= {qx[SUM_W-2:0], gex};
          qy <= {qy[SUM_W-2:0], gey};
          rx <= gex ? HIT_W'(shx - {1'b0, dv}) : shx[HIT_W-1:0];
          ry <= gey ? HIT_W'(shy - {1'b0, dv}) : shy[HIT_W-1:0];
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) state <= B_DONE;
        end
        B_DONE: begin
          if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase

      if (direct || (state == B_DONE && out_free)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (direct) begin
      m_tlast <= word.frame_end;
      m_tdata <= {7'b0, word.frame_end ? NONE : '0, word.frame_end ? NONE : '0,
                  word.in_mask};
    end else if (state == B_DONE && out_free) begin
      m_tlast <= 1'b1;
      m_tdata <= {7'b0, qy[OUT_W-1:0], qx[OUT_W-1:0], inside_r};
    end
  end

endmodule

FILE: hdl/mcm_checker.sv
// Port-level checker for the color mask centroid unit, with its bind
`timescale 1ns / 1ps
`include "mahalanobis_color_mask_centroid_unit_macros.svh"
module mcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);
  `MCM_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")
  `MCM_ASSERT_NOW(a_no_centroid, m_tvalid && !m_tlast, m_tdata[24:1] == 24'd0, "centroid set off frame end")
  `MCM_ASSERT_NOW(a_reset_idle, $past(rst), !m_tvalid, "output valid right after reset")
endmodule

bind mahalanobis_color_mask_centroid_unit mcm_checker u_checker (
  .clk(clk), .rst(rst),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
